// ===== design/poic_pkg.sv =====
package poic_pkg;

  // Field widths
  localparam int unsigned POS_W    = 16;
  localparam int unsigned ROW_W    = 32;
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned EBITS_W  = 7;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned BADDR_W  = 23;  // bit address of an entry: pos * width
  localparam int unsigned WIDX_W   = 18;  // word index, one more than needed for wi + 1
  localparam int unsigned SHIFT_W  = 6;
  localparam int unsigned CFG_AW   = 3;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_ENTRY_BITS    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_VALUE_OFFSET  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_FIRST_ROW     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ENTRY_COUNT   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_NULLS_PRESENT = 3'd4;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Effective configuration, already clamped
  typedef struct packed {
    logic [EBITS_W-1:0] width;      // 1..64
    logic [VAL_W-1:0]   offset;
    logic [ROW_W-1:0]   first_row;
    logic [COUNT_W-1:0] count;      // clamped to the entry capacity
    logic               has_nulls;
  } cfg_t;

  // Low mask of w bits, w in 1..64
  function automatic logic [VAL_W-1:0] width_mask(input logic [EBITS_W-1:0] w);
    logic [VAL_W-1:0] m;
    if (w >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << w[SHIFT_W-1:0]) - 64'd1;
    end
    return m;
  endfunction

endpackage

// ===== design/poic_regs.sv =====
module poic_regs #(
  parameter int unsigned MAX_ENTRIES = 65536
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [poic_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [poic_pkg::VAL_W-1:0]   cfg_wdata,
  output poic_pkg::cfg_t               cfg
);
  import poic_pkg::*;

  logic [EBITS_W-1:0] width_r;
  logic [VAL_W-1:0]   offset_r;
  logic [ROW_W-1:0]   first_row_r;
  logic [COUNT_W-1:0] count_r;
  logic               nulls_r;
  logic [EBITS_W-1:0] ebits_in;
  logic [COUNT_W-1:0] count_in;

  // Clamp width to 1..64 and count to capacity as they are written
  assign ebits_in = cfg_wdata[EBITS_W-1:0];
  assign count_in = cfg_wdata[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= 7'd8;
      offset_r    <= '0;
      first_row_r <= '0;
      count_r     <= '0;
      nulls_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ENTRY_BITS: begin
          if (ebits_in == '0) begin
            width_r <= 7'd1;
          end else if (ebits_in > 7'd64) begin
            width_r <= 7'd64;
          end else begin
            width_r <= ebits_in;
          end
        end
        REG_VALUE_OFFSET: offset_r <= cfg_wdata;
        REG_FIRST_ROW:    first_row_r <= cfg_wdata[ROW_W-1:0];
        REG_ENTRY_COUNT: begin
          if (32'(count_in) > 32'(MAX_ENTRIES)) begin
            count_r <= COUNT_W'(MAX_ENTRIES);
          end else begin
            count_r <= count_in;
          end
        end
        REG_NULLS_PRESENT: nulls_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg.width     = width_r;
  assign cfg.offset    = offset_r;
  assign cfg.first_row = first_row_r;
  assign cfg.count     = count_r;
  assign cfg.has_nulls = nulls_r;

endmodule

// ===== design/poic_bank.sv =====
module poic_bank #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [poic_pkg::VAL_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [poic_pkg::VAL_W-1:0]  rd_data
);
  import poic_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/packed_offset_integer_column.sv =====
// Packed offset integer column: signed 64-bit values stored as narrow codes,
// packed end to end in 64-bit words held in an even and an odd word bank.
// Configuration: cfg_we/cfg_addr/cfg_wdata, to be written only while idle (unchecked).
// Input words: tuser[0] selects write (0) or read (1). A write stores
// write_value at entry_pos (or a null, if nulls are enabled); a read names an
// absolute row_number. Every input word yields one output word: read_value in
// out_tdata, with is_null and write_done flags in out_tuser.
// Timing: an accepted word passes through ST_MUL, ST_RD, ST_EXT and ST_FIN;
// its result is offered as the block returns to idle, and the next input word
// can be taken in that same cycle. The read-modify-write through the two banks,
// each with a registered read, sets the length of this sequence; a field that
// straddles two words costs nothing extra because both words are read together.
// Reset: rst_n is synchronous. Control and configuration registers return to
// their defaults and the banks are swept to zero, one even/odd word pair per
// cycle; in_tready stays low during the sweep.
// Stalls: a result waits in the output register while out_tready is low; one
// more input word can be accepted meanwhile and is held back before its own
// result is loaded.
module packed_offset_integer_column #(
  parameter int unsigned STORE_WORDS = 1024,
  parameter int unsigned MAX_ENTRIES = 65536
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [poic_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [poic_pkg::VAL_W-1:0]   cfg_wdata,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [111:0]                 in_tdata,  // entry_pos, write_value, row_number
  input  logic [1:0]                   in_tuser,  // cmd, write_null
  // output stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [63:0]                  out_tdata, // read_value
  output logic [1:0]                   out_tuser  // is_null, write_done
);
  import poic_pkg::*;

  localparam int unsigned EDEPTH = (STORE_WORDS + 1) / 2;
  localparam int unsigned ODEPTH = STORE_WORDS / 2;
  localparam int unsigned EAW    = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
  localparam int unsigned OAW    = (ODEPTH > 1) ? $clog2(ODEPTH) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_RD,
    ST_EXT,
    ST_FIN
  } state_t;

  cfg_t cfg;

  state_t           state_r, state_nxt;
  logic [EAW-1:0]   clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload of the item at work
  logic             cmd_r;
  logic             act_r;
  logic [COUNT_W-1:0] pos_r;
  logic [VAL_W-1:0] code_r;
  logic [BADDR_W-1:0] baddr_r;
  logic [VAL_W-1:0] ext_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_null_r;
  logic             out_done_r;

  // input field views
  logic             in_cmd;
  logic             in_wnull;
  logic [POS_W-1:0] in_pos;
  logic [VAL_W-1:0] in_value;
  logic [ROW_W-1:0] in_row;
  logic [ROW_W-1:0] rel_row;
  logic             row_ok;
  logic             pos_ok;
  logic             accept;

  // word addressing
  logic [WIDX_W-1:0]  wi;
  logic [SHIFT_W-1:0] sh;
  logic               par;
  logic [WIDX_W-1:0]  even_idx;
  logic [WIDX_W-1:0]  odd_idx;
  logic               even_ok;
  logic               odd_ok;
  logic [EAW-1:0]     even_addr;
  logic [OAW-1:0]     odd_addr;

  // bank ports
  logic               e_wr_en, o_wr_en, e_rd_en, o_rd_en;
  logic [EAW-1:0]     e_wr_addr;
  logic [OAW-1:0]     o_wr_addr;
  logic [VAL_W-1:0]   e_wr_data, o_wr_data;
  logic [VAL_W-1:0]   e_rd_data, o_rd_data;

  // extract and merge
  logic [VAL_W-1:0]   mask;
  logic [VAL_W-1:0]   lo_word, hi_word;
  logic [127:0]       pair_sh;
  logic [127:0]       m128, d128;
  logic [VAL_W-1:0]   new_lo, new_hi;
  logic [VAL_W-1:0]   dec_value;
  logic               load_out;

  poic_regs #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Unpack the input word
  assign in_cmd   = in_tuser[0];
  assign in_wnull = in_tuser[1];
  assign in_pos   = in_tdata[15:0];
  assign in_value = in_tdata[79:16];
  assign in_row   = in_tdata[111:80];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Range checks for reads and writes
  assign rel_row = in_row - cfg.first_row;
  assign row_ok  = (in_row >= cfg.first_row) && (33'(rel_row) < 33'(cfg.count));
  assign pos_ok  = (COUNT_W'(in_pos) < cfg.count);

  // Split the bit address into word index and shift
  assign wi  = WIDX_W'(baddr_r[BADDR_W-1:SHIFT_W]);
  assign sh  = baddr_r[SHIFT_W-1:0];
  assign par = wi[0];
  assign even_idx  = par ? (wi + 1'b1) : wi;
  assign odd_idx   = par ? wi : (wi + 1'b1);
  assign even_ok   = (32'(even_idx) < 32'(STORE_WORDS));
  assign odd_ok    = (32'(odd_idx) < 32'(STORE_WORDS));
  assign even_addr = EAW'(even_idx >> 1);
  assign odd_addr  = OAW'(odd_idx >> 1);

  assign mask = width_mask(cfg.width);

  // Arrange bank data as low and high word; words beyond the store read zero
  always_comb begin
    logic [VAL_W-1:0] e_q;
    logic [VAL_W-1:0] o_q;
    e_q = even_ok ? e_rd_data : '0;
    o_q = odd_ok  ? o_rd_data : '0;
    lo_word = par ? o_q : e_q;
    hi_word = par ? e_q : o_q;
  end

  assign pair_sh = {hi_word, lo_word} >> sh;
  assign m128    = {64'd0, mask} << sh;
  assign d128    = {64'd0, code_r & mask} << sh;
  assign new_lo  = (lo_word & ~m128[63:0])   | d128[63:0];
  assign new_hi  = (hi_word & ~m128[127:64]) | d128[127:64];

  // Bank control: clearing sweep, read in ST_RD, write back in ST_EXT
  always_comb begin
    e_rd_en   = (state_r == ST_RD);
    o_rd_en   = (state_r == ST_RD);
    e_wr_en   = 1'b0;
    o_wr_en   = 1'b0;
    e_wr_addr = even_addr;
    o_wr_addr = odd_addr;
    e_wr_data = par ? new_hi : new_lo;
    o_wr_data = par ? new_lo : new_hi;
    if (state_r == ST_CLEAR) begin
      e_wr_en   = 1'b1;
      o_wr_en   = (32'(clr_r) < 32'(ODEPTH));
      e_wr_addr = clr_r;
      o_wr_addr = OAW'(clr_r);
      e_wr_data = '0;
      o_wr_data = '0;
    end else if (state_r == ST_EXT && cmd_r == CMD_WRITE && act_r) begin
      e_wr_en = even_ok;
      o_wr_en = odd_ok;
    end
  end

  poic_bank #(
    .DEPTH (EDEPTH),
    .AW    (EAW)
  ) u_even (
    .clk     (clk),
    .wr_en   (e_wr_en),
    .wr_addr (e_wr_addr),
    .wr_data (e_wr_data),
    .rd_en   (e_rd_en),
    .rd_addr (even_addr),
    .rd_data (e_rd_data)
  );

  poic_bank #(
    .DEPTH (ODEPTH),
    .AW    (OAW)
  ) u_odd (
    .clk     (clk),
    .wr_en   (o_wr_en),
    .wr_addr (o_wr_addr),
    .wr_data (o_wr_data),
    .rd_en   (o_rd_en),
    .rd_addr (odd_addr),
    .rd_data (o_rd_data)
  );

  // Decode: add the offset back, less one when code zero is reserved
  assign dec_value = ext_r + cfg.offset - VAL_W'(cfg.has_nulls);
  assign load_out  = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == EAW'(EDEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_EXT;
      ST_EXT:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // capture the item and form its code
    if (accept) begin
      cmd_r <= in_cmd;
      if (in_cmd == CMD_WRITE) begin
        act_r <= pos_ok;
        pos_r <= COUNT_W'(in_pos);
      end else begin
        act_r <= row_ok;
        pos_r <= rel_row[COUNT_W-1:0];
      end
      if (cfg.has_nulls) begin
        code_r <= in_wnull ? '0 : (in_value - cfg.offset + 64'd1);
      end else begin
        code_r <= in_value - cfg.offset;
      end
    end
    // bit address of the entry
    if (state_r == ST_MUL) begin
      baddr_r <= BADDR_W'(pos_r) * BADDR_W'(cfg.width);
    end
    // pull the field out of the word pair
    if (state_r == ST_EXT) begin
      ext_r <= pair_sh[63:0] & mask;
    end
    // load the result word
    if (load_out) begin
      if (cmd_r == CMD_WRITE) begin
        out_value_r <= '0;
        out_null_r  <= 1'b0;
        out_done_r  <= 1'b1;
      end else if (!act_r || (cfg.has_nulls && ext_r == '0)) begin
        out_value_r <= '0;
        out_null_r  <= 1'b1;
        out_done_r  <= 1'b0;
      end else begin
        out_value_r <= dec_value;
        out_null_r  <= 1'b0;
        out_done_r  <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_done_r, out_null_r};

endmodule

// ===== dv/column_mirror_pkg.sv =====
`timescale 1ns / 1ps
package column_mirror_pkg;
  import poic_pkg::*;

  localparam int unsigned STORE_WORDS = 1024;
  localparam int unsigned MAX_ENTRIES = 65536;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             is_null;
    logic             write_done;
  } row_word_t;

  // Shadow copy of the packed column: registers, word store and pending results
  class column_mirror;
    bit [63:0]        words [STORE_WORDS];
    bit [EBITS_W-1:0] ebits;
    bit [VAL_W-1:0]   offset;
    bit [ROW_W-1:0]   first_row;
    bit [COUNT_W-1:0] count;
    bit               nulls;
    row_word_t        due_results[$];
    int unsigned      mismatches;

    function new();
      ebits = 7'd8;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, logic [VAL_W-1:0] data);
      case (idx)
        REG_ENTRY_BITS:    ebits = data[EBITS_W-1:0];
        REG_VALUE_OFFSET:  offset = data;
        REG_FIRST_ROW:     first_row = data[ROW_W-1:0];
        REG_ENTRY_COUNT:   count = data[COUNT_W-1:0];
        REG_NULLS_PRESENT: nulls = data[0];
        default: ;
      endcase
    endfunction

    // Zero width acts as one, anything above 64 as 64
    function int unsigned eff_width();
      if (ebits == 0) return 1;
      if (ebits > 64) return 64;
      return 32'(ebits);
    endfunction

    function int unsigned eff_count();
      return (count > MAX_ENTRIES) ? MAX_ENTRIES : 32'(count);
    endfunction

    function logic [63:0] code_mask();
      int unsigned w;
      w = eff_width();
      return (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    // Apply one accepted word to the store and queue the result it yields
    function void note_item(logic cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] wval,
                            logic wnull, logic [ROW_W-1:0] row);
      int unsigned w, addr, wi, sh;
      logic [63:0]  mask, code;
      logic [127:0] field, pair;
      row_word_t    r;
      w = eff_width();
      mask = code_mask();
      r = '0;
      if (cmd == CMD_WRITE) begin
        r.write_done = 1'b1;
        if (pos < eff_count()) begin
          if (nulls) code = wnull ? 64'd0 : wval - offset + 64'd1;
          else code = wval - offset;
          addr = pos * w;
          wi = addr / 64;
          sh = addr % 64;
          field = {64'd0, mask} << sh;
          pair = {64'd0, code & mask} << sh;
          // drop any part that lands past the end of the store
          if (wi < STORE_WORDS)
            words[wi] = (words[wi] & ~field[63:0]) | pair[63:0];
          if (wi + 1 < STORE_WORDS)
            words[wi + 1] = (words[wi + 1] & ~field[127:64]) | pair[127:64];
        end
      end else begin
        r.is_null = 1'b1;
        if (row >= first_row && row - first_row < eff_count()) begin
          addr = (row - first_row) * w;
          wi = addr / 64;
          sh = addr % 64;
          pair = {(wi + 1 < STORE_WORDS) ? words[wi + 1] : 64'd0,
                  (wi < STORE_WORDS) ? words[wi] : 64'd0};
          pair = pair >> sh;
          code = pair[63:0] & mask;
          if (!nulls) begin
            r.value = code + offset;
            r.is_null = 1'b0;
          end else if (code != 0) begin
            r.value = code + offset - 64'd1;
            r.is_null = 1'b0;
          end
        end
      end
      due_results = {due_results, r};
    endfunction

    // Compare one output word against the oldest pending result
    function void check_word(logic [VAL_W-1:0] value, logic is_null, logic write_done);
      row_word_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word: read_value %h is_null %b write_done %b",
                   value, is_null, write_done);
      end else begin
        want = due_results.pop_front();
        if (value !== want.value || is_null !== want.is_null ||
            write_done !== want.write_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: exp read_value %h is_null %b write_done %b, ",
                      "got read_value %h is_null %b write_done %b"},
                     want.value, want.is_null, want.write_done,
                     value, is_null, write_done);
        end
      end
    endfunction
  endclass

endpackage

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import poic_pkg::*;
  import column_mirror_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [VAL_W-1:0]  cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [111:0]      in_tdata = '0;  // entry_pos, write_value, row_number
  logic [1:0]        in_tuser = '0;  // cmd, write_null
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [63:0]       out_tdata;      // read_value
  logic [1:0]        out_tuser;      // is_null, write_done

  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  column_mirror      mirror;
  logic [POS_W-1:0]  written[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  packed_offset_integer_column u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Track accepted words on both sides
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      mirror.check_word(out_tdata, out_tuser[0], out_tuser[1]);
    if (rst_n && in_tvalid && in_tready)
      mirror.note_item(in_tuser[0], in_tdata[15:0], in_tdata[79:16], in_tuser[1],
                       in_tdata[111:80]);
  end

  // Offer one input word, idling first at random, and hold until accepted
  task automatic send_word(logic cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] wval,
                           logic wnull, logic [ROW_W-1:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row, wval, pos};
    in_tuser  <= {wnull, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_entry(logic [POS_W-1:0] pos, logic [VAL_W-1:0] wval, logic wnull);
    send_word(CMD_WRITE, pos, wval, wnull, $urandom());
  endtask

  task automatic read_row(logic [ROW_W-1:0] row);
    send_word(CMD_READ, POS_W'($urandom()), {$urandom(), $urandom()},
              1'($urandom_range(1)), row);
  endtask

  // Hold the input side until every pending result is out, then settle
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (mirror.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [VAL_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    mirror.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Reprogram all registers while the block is idle
  task automatic apply_setting(logic [EBITS_W-1:0] ebits, logic [VAL_W-1:0] off,
                               logic [ROW_W-1:0] first, logic [COUNT_W-1:0] cnt,
                               logic nul);
    wait_for_results();
    write_reg(REG_ENTRY_BITS, VAL_W'(ebits));
    write_reg(REG_VALUE_OFFSET, off);
    write_reg(REG_FIRST_ROW, VAL_W'(first));
    write_reg(REG_ENTRY_COUNT, VAL_W'(cnt));
    write_reg(REG_NULLS_PRESENT, VAL_W'(nul));
    cfg_we <= 1'b0;
    written.delete();
  endtask

  task automatic random_setting();
    logic [EBITS_W-1:0] ebits;
    logic [VAL_W-1:0]   off;
    logic [ROW_W-1:0]   first;
    logic [COUNT_W-1:0] cnt;
    case ($urandom_range(5))
      0:       ebits = 7'd0;
      1:       ebits = 7'd127;
      2:       ebits = 7'd64;
      3:       ebits = 7'd1;
      default: ebits = EBITS_W'($urandom_range(1, 64));
    endcase
    case ($urandom_range(3))
      0:       off = 64'h8000_0000_0000_0000;
      1:       off = 64'h7FFF_FFFF_FFFF_FFFF;
      2:       off = 64'd0;
      default: off = {$urandom(), $urandom()};
    endcase
    case ($urandom_range(4))
      0:       first = 32'd0;
      1:       first = 32'hFFFF_FFFF;
      2:       first = $urandom();
      default: first = $urandom_range(0, 1000);
    endcase
    case ($urandom_range(5))
      0:       cnt = 17'd0;
      1:       cnt = 17'd65536;
      2:       cnt = 17'h1FFFF;
      3:       cnt = COUNT_W'($urandom_range(0, 131071));
      default: cnt = COUNT_W'($urandom_range(1, 40));
    endcase
    apply_setting(ebits, off, first, cnt, 1'($urandom_range(1)));
  endtask

  // Mostly writes inside the column and reads of rows already written
  task automatic run_random(int unsigned n);
    int unsigned      cnt, k;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] mask, val;
    cnt = mirror.eff_count();
    mask = mirror.code_mask();
    repeat (n) begin
      k = $urandom_range(99);
      if (k < 45) begin
        pos = POS_W'((cnt != 0 && $urandom_range(9) != 0) ? $urandom_range(cnt - 1)
                                                          : $urandom());
        val = {$urandom(), $urandom()};
        if ($urandom_range(3) != 0) val = mirror.offset + (val & (mask >> 1));
        if (pos < cnt) begin
          if (written.size() < 64) written = {written, pos};
          else written[$urandom_range(63)] = pos;
        end
        write_entry(pos, val, $urandom_range(3) == 0);
      end else if (k < 90 && cnt != 0) begin
        if (written.size() != 0 && $urandom_range(9) < 7)
          pos = written[$urandom_range(written.size() - 1)];
        else
          pos = POS_W'($urandom_range(cnt - 1));
        read_row(mirror.first_row + pos);
      end else begin
        case ($urandom_range(2))
          0:       read_row($urandom());
          1:       read_row(mirror.first_row - 32'd1);
          default: read_row(mirror.first_row + cnt);
        endcase
      end
    end
  endtask

  initial begin
    mirror = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 15;
    recv_idle_pct = 83;

    // Empty column after reset: read is null, write is dropped
    read_row(32'd0);
    write_entry(16'd0, 64'd1, 1'b0);

    // 13-bit codes with nulls, rows 100..119
    apply_setting(7'd13, -64'sd5, 32'd100, 17'd20, 1'b1);
    write_entry(16'd0, -64'sd5, 1'b0);
    write_entry(16'd4, 64'd1000, 1'b0);
    write_entry(16'd5, 64'd77, 1'b1);
    write_entry(16'd19, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    write_entry(16'd20, 64'd7, 1'b0);
    write_entry(16'hFFFF, 64'd1, 1'b0);
    read_row(32'd99);
    read_row(32'd100);
    read_row(32'd104);
    read_row(32'd105);
    read_row(32'd110);
    read_row(32'd119);
    read_row(32'd120);
    read_row(32'hFFFF_FFFF);

    // Zero width as one bit, count above capacity, null flag without nulls
    apply_setting(7'd0, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 17'h1FFFF, 1'b0);
    write_entry(16'hFFFF, 64'h8000_0000_0000_0000, 1'b1);
    read_row(32'd65535);
    read_row(32'd65536);
    read_row(32'd0);

    // Width above 64, first row at the top of the row space
    apply_setting(7'd127, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 17'd65536, 1'b1);
    write_entry(16'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    read_row(32'hFFFF_FFFF);
    read_row(32'd0);

    // Random phases: sender-light, receiver-light, then no idling
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (5) begin
        random_setting();
        run_random(100);
      end
    end

    wait_for_results();
    if (mirror.mismatches == 0 && mirror.due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20ms;
    $display("ERROR: timeout with %0d results outstanding", mirror.due_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
design/poic_pkg.sv
design/poic_regs.sv
design/poic_bank.sv
design/packed_offset_integer_column.sv
dv/column_mirror_pkg.sv
dv/tb.sv
